>>> hw/rtl/etic_pkg.sv
// Shared constants for the escape-time iteration counter.
// Used by the shared multiplier unit and the top level; no dependencies.
`default_nettype none

package etic_pkg;

  // Width of the z parts and of the exact products formed from them.
  localparam int unsigned ZW      = 64;
  localparam int unsigned PW      = 2 * ZW;
  localparam int unsigned HW      = ZW / 2;

  // Input coordinate and count widths.
  localparam int unsigned CW      = 32;
  localparam int unsigned CNTW    = 16;

  localparam int unsigned DEFAULT_FRAC_BITS = 27;
  localparam logic [CNTW-1:0] MAX_ITER_RESET = 16'd1000;

endpackage

`default_nettype wire

>>> hw/rtl/etic_mul64.sv
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier.
// Four partial products are issued on consecutive cycles and summed into a
// 128-bit accumulator. Depends on etic_pkg.
`default_nettype none

module etic_mul64
  import etic_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [ZW-1:0] a,
  input  wire logic [ZW-1:0] b,
  output logic               done,
  output logic [PW-1:0]      result
);

  logic [ZW-1:0] a_reg;
  logic [ZW-1:0] b_reg;
  logic          busy;
  logic [1:0]    step;
  logic [ZW-1:0] prod;
  logic          prod_vld;
  logic [1:0]    prod_step;
  logic [HW-1:0] a_half;
  logic [HW-1:0] b_half;
  logic [ZW-1:0] prod_comb;
  logic [PW-1:0] addend;

  // Step order: a0*b0, a0*b1, a1*b0, a1*b1.
  assign a_half    = step[1] ? a_reg[ZW-1:HW] : a_reg[HW-1:0];
  assign b_half    = step[0] ? b_reg[ZW-1:HW] : b_reg[HW-1:0];
  assign prod_comb = a_half * b_half;

  always_comb begin
    case (prod_step)
      2'd0:    addend = {{ZW{1'b0}}, prod};
      2'd1,
      2'd2:    addend = {{HW{1'b0}}, prod, {HW{1'b0}}};
      2'd3:    addend = {prod, {ZW{1'b0}}};
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
      step     <= '0;
    end else begin
      done     <= prod_vld && (prod_step == 2'd3);
      prod_vld <= busy;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg  <= a;
      b_reg  <= b;
      result <= '0;
    end else if (prod_vld) begin
      result <= result + addend;
    end
    prod      <= prod_comb;
    prod_step <= step;
  end

endmodule

`default_nettype wire

>>> hw/rtl/escape_time_iteration_counter_unit.sv
// Escape-time iteration counter: top level with the iteration sequencer.
// Depends on etic_pkg and etic_mul64.
//
// Usage:
//   s_axis carries one point c per transaction: tdata[31:0] is c_real and
//   tdata[63:32] is c_imag, both signed with FRAC_BITS fraction bits.
//   m_axis returns one iteration count per point in tdata[15:0].
//   cfg_wr_en / cfg_wr_data write the iteration limit (reset value 1000);
//   write it only while no point is in flight.
//   The block iterates z = z*z + c from z = 0 and stops when |z|^2 > 4 or
//   the count reaches the limit. Each 64x64 product is formed in the one
//   shared 32x32 multiplier, three products per iteration. The next point
//   is taken once the count has moved to the output register; s_axis_tready
//   is high only while the sequencer is idle.
//   The count sits in an output register, so the next point is accepted
//   while the previous count waits; if the receiver holds m_axis_tready
//   low, a finished point waits until that register is free.
//   Reset clears both channels and restores the limit to 1000.
`default_nettype none

module escape_time_iteration_counter_unit
  import etic_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] c_real, [63:32] c_imag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] iteration_count
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data     // iteration limit
);

  localparam int unsigned THR_SHIFT = 2 * FRAC_BITS + 2;
  localparam logic [PW-1:0] THRESHOLD = {{(PW-1){1'b0}}, 1'b1} << THR_SHIFT;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_LIMIT    = 9'b000000010,
    S_MUL_RI   = 9'b000000100,
    S_UPDATE   = 9'b000001000,
    S_ISSUE_RR = 9'b000010000,
    S_MUL_RR   = 9'b000100000,
    S_MUL_II   = 9'b001000000,
    S_ESCAPE   = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t          state;
  logic [CNTW-1:0] max_iter;
  logic [CNTW-1:0] count;
  logic [ZW-1:0]   cr;
  logic [ZW-1:0]   ci;
  logic [ZW-1:0]   zr;
  logic [ZW-1:0]   zi;
  logic [PW-1:0]   rr;
  logic [PW-1:0]   ii;
  logic [PW-1:0]   re;
  logic [PW-1:0]   im;

  logic [ZW-1:0]   zr_mag;
  logic [ZW-1:0]   zi_mag;
  logic            mul_start;
  logic [ZW-1:0]   mul_a;
  logic [ZW-1:0]   mul_b;
  logic            mul_done;
  logic [PW-1:0]   mul_result;
  logic [PW-1:0]   im_dbl;
  logic [PW-1:0]   m2;
  logic            at_limit;

  assign zr_mag   = zr[ZW-1] ? (~zr + 1'b1) : zr;
  assign zi_mag   = zi[ZW-1] ? (~zi + 1'b1) : zi;
  assign at_limit = (count >= max_iter);
  assign im_dbl   = {mul_result[PW-2:0], 1'b0};
  assign m2       = rr + ii;

  assign s_axis_tready = (state == S_IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = zr_mag;
    mul_b     = zi_mag;
    case (state)
      S_LIMIT: begin
        mul_start = !at_limit;
      end
      S_ISSUE_RR: begin
        mul_start = 1'b1;
        mul_b     = zr_mag;
      end
      S_MUL_RR: begin
        mul_start = mul_done;
        mul_a     = zi_mag;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  etic_mul64 u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_result)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      max_iter      <= MAX_ITER_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_iter <= cfg_wr_data;
      end
      if (state == S_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          state <= at_limit ? S_FINISH : S_MUL_RI;
        end
        S_MUL_RI: begin
          if (mul_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_ISSUE_RR;
        end
        S_ISSUE_RR: begin
          state <= S_MUL_RR;
        end
        S_MUL_RR: begin
          if (mul_done) begin
            state <= S_MUL_II;
          end
        end
        S_MUL_II: begin
          if (mul_done) begin
            state <= S_ESCAPE;
          end
        end
        S_ESCAPE: begin
          state <= (m2 > THRESHOLD) ? S_FINISH : S_LIMIT;
        end
        S_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cr    <= {{(ZW-CW){s_axis_tdata[CW-1]}}, s_axis_tdata[CW-1:0]};
        ci    <= {{(ZW-CW){s_axis_tdata[2*CW-1]}}, s_axis_tdata[2*CW-1:CW]};
        zr    <= '0;
        zi    <= '0;
        rr    <= '0;
        ii    <= '0;
        count <= '0;
      end
      S_MUL_RI: begin
        if (mul_done) begin
          re <= rr - ii;
          // The cross term takes a minus sign when zr and zi differ in sign.
          im <= (zr[ZW-1] != zi[ZW-1]) ? (~im_dbl + 1'b1) : im_dbl;
        end
      end
      S_UPDATE: begin
        zr <= re[FRAC_BITS +: ZW] + cr;
        zi <= im[FRAC_BITS +: ZW] + ci;
      end
      S_MUL_RR: begin
        if (mul_done) begin
          rr <= mul_result;
        end
      end
      S_MUL_II: begin
        if (mul_done) begin
          ii <= mul_result;
        end
      end
      S_ESCAPE: begin
        if (!(m2 > THRESHOLD)) begin
          count <= count + 1'b1;
        end
      end
      S_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= count;
        end
      end
      default: begin
        count <= count;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> verif/tb_escape_time_iteration_counter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for escape_time_iteration_counter_unit.
// Needs etic_pkg and the block's RTL; known counts come from the directed table,
// the rest from a fixed-point escape-time model of its own; checks each result.

module tb_escape_time_iteration_counter_unit;
  import etic_pkg::*;

  localparam int FRAC = DEFAULT_FRAC_BITS;
  localparam logic signed [127:0] ESCAPE_THRESHOLD = 128'sd1 <<< (2 * FRAC + 2);

  localparam logic [CW-1:0] Q_ZERO    = 32'h0000_0000;
  localparam logic [CW-1:0] Q_ONE     = 32'h0800_0000;
  localparam logic [CW-1:0] Q_TWO     = 32'h1000_0000;
  localparam logic [CW-1:0] Q_QUARTER = 32'h0200_0000;
  localparam logic [CW-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [CW-1:0] Q_MAX     = 32'h7FFF_FFFF;
  // Real points just right of the cusp at 0.25; they escape slowly.
  localparam logic [CW-1:0] Q_SLOW_A  = Q_QUARTER + Q_ONE / 10000;
  localparam logic [CW-1:0] Q_SLOW_B  = Q_QUARTER + Q_ONE / 100;
  localparam logic [CW-1:0] Q_SLOW_C  = Q_ONE * 3 / 10;

  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [CW-1:0]   c_re;
    logic [CW-1:0]   c_im;
    logic            known;
    logic [CNTW-1:0] count;
  } point_row_t;

  // Rows marked known carry the count that follows directly from the point
  // under the reset limit of 1000; the others go through the predictor.
  point_row_t directed_points [N_DIRECTED] = '{
    {Q_ZERO, Q_ZERO, 1'b1, 16'd1000},
    {Q_MIN, Q_MIN, 1'b1, 16'd0},
    {Q_MAX, Q_MAX, 1'b1, 16'd0},
    {Q_MIN, Q_MAX, 1'b1, 16'd0},
    {Q_MAX, Q_MIN, 1'b1, 16'd0},
    {Q_TWO, Q_ZERO, 1'b1, 16'd1},        // lands exactly on |z| = 2, then leaves
    {Q_ZERO, Q_TWO, 1'b1, 16'd1},
    {Q_ZERO, -Q_TWO, 1'b1, 16'd1},
    {-Q_TWO, Q_ZERO, 1'b1, 16'd1000},    // stays on the circle |z| = 2 forever
    {Q_TWO + 1, Q_ZERO, 1'b1, 16'd0},
    {-Q_TWO - 1, Q_ZERO, 1'b1, 16'd0},
    {-Q_ONE, Q_ZERO, 1'b1, 16'd1000},
    {Q_ZERO, Q_ONE, 1'b1, 16'd1000},
    {Q_QUARTER, Q_ZERO, 1'b0, 16'd0},
    {Q_QUARTER + 1, Q_ZERO, 1'b0, 16'd0},
    {Q_ONE, Q_ZERO, 1'b0, 16'd0},
    {32'h0000_0001, Q_ZERO, 1'b0, 16'd0},
    {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
    {32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'd0},
    {Q_QUARTER - Q_ONE, Q_ONE / 10, 1'b0, 16'd0}
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [63:0]     s_axis_tdata = '0;   // [31:0] c_real, [63:32] c_imag
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;        // [15:0] iteration_count
  logic            cfg_wr_en = 1'b0;
  logic [15:0]     cfg_wr_data = '0;    // iteration limit

  logic [CNTW-1:0] counts_due [$];
  logic [CNTW-1:0] due_count;
  logic [CNTW-1:0] iter_limit = MAX_ITER_RESET;
  int              mismatches = 0;
  int              burst_left = 0;
  bit              steady = 1'b0;
  int unsigned     ready_tick = 0;
  logic [12:0]     stall_mask = '0;

  escape_time_iteration_counter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Iterates z = z*z + c with exact double-width squares and floor rounding
  // of the fraction; the escape test uses the unrounded |z|^2.
  function automatic logic [CNTW-1:0] escape_count(input logic [CW-1:0] c_re,
                                                   input logic [CW-1:0] c_im,
                                                   input logic [CNTW-1:0] limit);
    logic signed [ZW-1:0] zr, zi;
    logic signed [PW-1:0] wr, wi, re_sum, im_sum, mag2;
    logic [CNTW-1:0]      n;
    bit                   escaped;
    zr = '0;
    zi = '0;
    n = '0;
    escaped = 1'b0;
    while (n < limit && !escaped) begin
      wr = zr;
      wi = zi;
      re_sum = wr * wr - wi * wi;
      im_sum = (wr * wi) <<< 1;
      zr = re_sum[FRAC +: ZW] + {{(ZW-CW){c_re[CW-1]}}, c_re};
      zi = im_sum[FRAC +: ZW] + {{(ZW-CW){c_im[CW-1]}}, c_im};
      wr = zr;
      wi = zi;
      mag2 = wr * wr + wi * wi;
      if (mag2 > ESCAPE_THRESHOLD) begin
        escaped = 1'b1;
      end else begin
        n++;
      end
    end
    return n;
  endfunction

  // Offers one point, with a random gap in front of each burst outside steady mode, and records
  // the count it must produce once the transaction is taken.
  task automatic push_point(input logic [CW-1:0] c_re, input logic [CW-1:0] c_im,
                            input logic known, input logic [CNTW-1:0] count);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 :
            ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4));
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {c_im, c_re};
    do @(posedge clk); while (!s_axis_tready);
    counts_due.push_back(known ? count : escape_count(c_re, c_im, iter_limit));
  endtask

  // The limit may only change with no point in flight.
  task automatic set_iteration_limit(input logic [CNTW-1:0] value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (counts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    iter_limit = value;
  endtask

  // The receiver walks a 13-bit stall mask that is redrawn now and then,
  // sometimes to all zeros so that long stretches see no stall at all.
  always @(negedge clk) begin
    ready_tick++;
    if (ready_tick % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mask = '0;
        1: stall_mask = 13'h1FFE;
        default: stall_mask = 13'($urandom);
      endcase
    end
    m_axis_tready = !stall_mask[ready_tick % 13];
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (counts_due.size() == 0) begin
        $display("%0t: result transaction with none expected: iteration_count %0d",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        due_count = counts_due.pop_front();
        if (m_axis_tdata !== due_count) begin
          $display("%0t: iteration_count expected %0d, actual %0d",
                   $time, due_count, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [CNTW-1:0] next_limit;
    logic [CW-1:0]   c_re, c_im, far_mag;
    int              n_points;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      push_point(directed_points[i].c_re, directed_points[i].c_im,
                 directed_points[i].known, directed_points[i].count);
    end

    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: next_limit = '0;
        1: next_limit = 16'd1;
        2: next_limit = '1;
        default: next_limit = $urandom_range(2, 40);
      endcase
      n_points = (phase == 0 || phase == 2) ? 40 : (phase == 1 ? 120 : 150);
      set_iteration_limit(next_limit);
      steady = ($urandom_range(0, 2) == 0);
      burst_left = 0;
      for (int k = 0; k < n_points; k++) begin
        if (iter_limit == '1) begin
          // Under the largest limit only points that escape are used, some of them slowly.
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
              0: begin c_re = Q_TWO;    c_im = Q_ZERO; end
              1: begin c_re = Q_ZERO;   c_im = -Q_TWO; end
              2: begin c_re = Q_SLOW_A; c_im = Q_ZERO; end
              3: begin c_re = Q_SLOW_B; c_im = Q_ZERO; end
              default: begin c_re = Q_SLOW_C; c_im = Q_ZERO; end
            endcase
          end else begin
            far_mag = $urandom_range(Q_TWO + 1, Q_MAX);
            c_re = $urandom_range(0, 1) ? far_mag : -far_mag;
            c_im = $urandom;
          end
        end else begin
          case ($urandom_range(0, 9))
            0, 1: begin
              c_re = $urandom;
              c_im = $urandom;
            end
            2: begin
              // Half-unit grid over [-2, 2], which hits the circle |c| = 2.
              c_re = ($urandom_range(0, 8) - 4) * (Q_ONE / 2);
              c_im = ($urandom_range(0, 8) - 4) * (Q_ONE / 2);
            end
            default: begin
              c_re = $urandom_range(0, Q_TWO + Q_ONE / 2) - Q_TWO;
              c_im = $urandom_range(0, Q_ONE * 12 / 5) - Q_ONE * 6 / 5;
            end
          endcase
        end
        push_point(c_re, c_im, 1'b0, '0);
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (counts_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[escape_time_iteration_counter_unit] OK");
    end else begin
      $display("[escape_time_iteration_counter_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("%0t: timed out", $time);
    $display("[escape_time_iteration_counter_unit] ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/etic_pkg.sv
hw/rtl/etic_mul64.sv
hw/rtl/escape_time_iteration_counter_unit.sv
verif/tb_escape_time_iteration_counter_unit.sv
